/* rtl/nnar_pkg.sv */
// shared widths, register indexes, reset values and phase unit types for the resampler
package nnar_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RATE_W   = 18;
  localparam int PHASE_W  = 19;
  localparam int CFG_IDX_W = 2;
  localparam int RUN_CAP  = 64;
  localparam int COUNT_W  = $clog2(RUN_CAP + 1);

  localparam logic [RATE_W-1:0] SRC_RATE_RST    = RATE_W'(48000);
  localparam logic [RATE_W-1:0] DST_RATE_RST    = RATE_W'(48000);
  localparam logic              STEREO_MODE_RST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_RATE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DST_RATE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE = 2'd2;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic               carry;
    logic [PHASE_W-1:0] value;
  } alu_res_t;

endpackage

/* rtl/nnar_alu.sv */
// shared phase adder: phase plus source rate, or phase minus output rate with no-borrow flag
module nnar_alu import nnar_pkg::*; (
  input  alu_op_t             op,
  input  logic [PHASE_W-1:0]  a,
  input  logic [RATE_W-1:0]   rate,
  output alu_res_t            res
);

  logic [PHASE_W-1:0] b;
  logic               cin;

  // subtract as a + ~b + 1, carry out high means a >= rate
  assign b   = (op == ALU_ADD) ? {1'b0, rate} : ~{1'b0, rate};
  assign cin = (op == ALU_SUB);
  assign res = {1'b0, a} + {1'b0, b} + {{PHASE_W{1'b0}}, cin};

endmodule

/* rtl/nearest_neighbour_audio_resampler.sv */
// nearest-neighbour resampler: phase sequencer around one shared adder, output register
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_stall, left_sample, right_sample | sink
//  out     | out_valid, out_stall, out_left, out_right,    | source
//          | last_of_run                                   |
//  cfg     | cfg_we, cfg_index, cfg_data                   | sink
//
// a source frame is either dropped after its drop check or gives n output beats
// (n at most 64, the run cap); each output costs one add and one compare
// on the single shared phase adder. in_stall is high from acceptance until the run ends.
// a stalled output beat holds the sequencer in its compare step.
// rst is synchronous: phase clears, registers take their reset values.
module nearest_neighbour_audio_resampler import nnar_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [RATE_W-1:0]          cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] left_sample,
  input  logic signed [SAMPLE_W-1:0] right_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_left,
  output logic signed [SAMPLE_W-1:0] out_right,
  output logic                       last_of_run
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_ADD,
    S_CMP
  } state_t;

  state_t                      state;
  logic [RATE_W-1:0]           src_rate;
  logic [RATE_W-1:0]           dst_rate;
  logic                        stereo_mode;
  logic [PHASE_W-1:0]          phase;
  logic [COUNT_W-1:0]          count;
  logic signed [SAMPLE_W-1:0]  hold_left;
  logic signed [SAMPLE_W-1:0]  hold_right;

  alu_op_t                     alu_op;
  logic [RATE_W-1:0]           alu_rate;
  alu_res_t                    alu_res;
  logic                        in_beat;
  logic                        slot_free;
  logic                        out_load;
  logic                        run_full;

  assign in_stall  = (state != S_IDLE);
  assign in_beat   = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign out_load  = (state == S_CMP) && slot_free;
  assign run_full  = (count == COUNT_W'(RUN_CAP));
  assign alu_op    = (state == S_ADD) ? ALU_ADD : ALU_SUB;
  assign alu_rate  = (state == S_ADD) ? src_rate : dst_rate;

  nnar_alu u_alu (
    .op   (alu_op),
    .a    (phase),
    .rate (alu_rate),
    .res  (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      src_rate    <= SRC_RATE_RST;
      dst_rate    <= DST_RATE_RST;
      stereo_mode <= STEREO_MODE_RST;
      phase       <= '0;
      count       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_RATE:    src_rate <= cfg_data;
          REG_DST_RATE:    dst_rate <= cfg_data;
          REG_STEREO_MODE: stereo_mode <= cfg_data[0];
          default: ;
        endcase
      end

      // load a new beat, or free the register once its beat is taken
      if (out_load) begin
        out_valid   <= 1'b1;
        out_left    <= hold_left;
        out_right   <= hold_right;
        last_of_run <= alu_res.carry || run_full;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_beat) begin
            hold_left  <= left_sample;
            hold_right <= stereo_mode ? right_sample : left_sample;
            state      <= S_CHECK;
          end
        end
        S_CHECK: begin
          count <= '0;
          if (alu_res.carry) begin
            // phase already at or past the output rate: drop this frame
            phase <= alu_res.value;
            state <= S_IDLE;
          end else begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          phase <= alu_res.value;
          count <= count + COUNT_W'(1);
          state <= S_CMP;
        end
        S_CMP: begin
          if (slot_free) begin
            if (alu_res.carry) begin
              phase <= alu_res.value;
              state <= S_IDLE;
            end else if (run_full) begin
              // run cap reached: phase keeps its sum
              state <= S_IDLE;
            end else begin
              state <= S_ADD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // run length never passes the cap
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(RUN_CAP))
    else $error("run count above cap");

  // an accepted frame always starts with the drop check
  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> state == S_CHECK)
    else $error("accepted frame did not enter check");

  // a stalled result holds the sequencer in its compare step
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP && out_valid && out_stall) |=> state == S_CMP)
    else $error("sequencer moved while output stalled");

  // a beat is only issued from the compare step
  a_beat_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_CMP)
    else $error("output beat from wrong step");

endmodule
